// File: src/rgl_pkg.sv
`default_nettype none
package rgl_pkg;

    localparam int NUM_CH = 4;
    localparam int SMP_W  = 24;
    localparam int LVL_W  = 24;
    localparam int ACC_W  = 44;
    localparam int FRM_W  = 24;
    localparam int CNT_W  = 32;
    localparam int ID_W   = 16;
    localparam int FRAC_X = ACC_W - LVL_W;

    localparam logic signed [LVL_W-1:0] ONE_Q20 = 24'sd1048576;
    localparam logic signed [ACC_W-1:0] MAX_ACC = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] MIN_ACC = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_NODE  = 2'd1;
    localparam logic [1:0] CFG_PARAM = 2'd2;
    localparam logic [1:0] CFG_INIT  = 2'd3;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic signed [SMP_W-1:0] sample_0;
        logic signed [SMP_W-1:0] sample_1;
        logic signed [SMP_W-1:0] sample_2;
        logic signed [SMP_W-1:0] sample_3;
        logic [NUM_CH-1:0]       bad_mask;
        logic signed [LVL_W-1:0] event_level;
        logic                    event_linear;
        logic [FRM_W-1:0]        event_ramp_frames;
        logic [ID_W-1:0]         event_node;
        logic [ID_W-1:0]         event_param;
    } t_in_beat;

    typedef struct packed {
        logic signed [SMP_W-1:0] out_0;
        logic signed [SMP_W-1:0] out_1;
        logic signed [SMP_W-1:0] out_2;
        logic signed [SMP_W-1:0] out_3;
        logic [CNT_W-1:0]        bad_count;
    } t_out_beat;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend;
        logic [FRM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic signed [LVL_W-1:0] normalize(
        input logic                    limiter,
        input logic signed [LVL_W-1:0] lvl
    );
        logic signed [LVL_W-1:0] res;
        res = lvl;
        if (limiter && (lvl <= 0 || lvl > ONE_Q20)) begin
            res = ONE_Q20;
        end
        return res;
    endfunction

    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [28:0] v);
        logic signed [SMP_W-1:0] res;
        if (v > 29'sd8388607) begin
            res = {1'b0, {(SMP_W-1){1'b1}}};
        end else if (v < -29'sd8388608) begin
            res = {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            res = v[SMP_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: src/rgl_lane.sv
`default_nettype none
module rgl_lane (
    input  wire                                 i_clk,
    input  wire                                 i_en,
    input  wire logic signed [rgl_pkg::SMP_W-1:0] i_sample,
    input  wire                                 i_bad,
    input  wire logic signed [rgl_pkg::LVL_W-1:0] i_level,
    input  wire                                 i_limiter,
    output logic signed [rgl_pkg::SMP_W-1:0]      o_result
);
    import rgl_pkg::*;

    logic signed [SMP_W-1:0]       w_smp;
    logic signed [27:0]            w_thr;
    logic signed [27:0]            w_nthr;
    logic signed [27:0]            w_s28;
    logic signed [27:0]            w_c1;
    logic signed [27:0]            w_c2;
    logic signed [SMP_W+LVL_W-1:0] n_prod;
    logic signed [SMP_W-1:0]       n_clip;
    logic signed [SMP_W+LVL_W-1:0] r_prod;
    logic signed [SMP_W-1:0]       r_clip;
    logic                          r_lim;
    logic signed [SMP_W+LVL_W:0]   w_rnd;

    always_comb begin
        w_smp  = i_bad ? '0 : i_sample;
        w_thr  = {i_level[LVL_W-1], i_level, 3'b000};
        w_nthr = -w_thr;
        w_s28  = {{(28-SMP_W){w_smp[SMP_W-1]}}, w_smp};
        w_c1   = (w_s28 > w_thr) ? w_thr : w_s28;
        w_c2   = (w_c1 < w_nthr) ? w_nthr : w_c1;
        n_clip = sat_smp({w_c2[27], w_c2});
        n_prod = w_smp * i_level;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_clip <= n_clip;
            r_lim  <= i_limiter;
        end
    end

    // round half up, drop 20 fraction bits
    always_comb begin
        w_rnd    = {r_prod[SMP_W+LVL_W-1], r_prod} + 49'sd524288;
        o_result = r_lim ? r_clip : sat_smp(w_rnd[48:20]);
    end

endmodule
`default_nettype wire

// File: src/rgl_div.sv
`default_nettype none
module rgl_div (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire rgl_pkg::t_div_req i_req,
    output rgl_pkg::t_div_rsp      o_rsp
);
    import rgl_pkg::*;

    logic             r_run;
    logic             r_done;
    logic [5:0]       r_cnt;
    logic [FRM_W-1:0] r_rem;
    logic [ACC_W-1:0] r_quo;
    logic [FRM_W-1:0] r_dvs;
    logic [FRM_W:0]   w_trial;
    logic             w_ge;
    logic [FRM_W:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[ACC_W-1]};
        w_ge    = w_trial >= {1'b0, r_dvs};
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= 6'(ACC_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit a cycle, msb first
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_run) begin
            r_rem <= w_ge ? w_diff[FRM_W-1:0] : w_trial[FRM_W-1:0];
            r_quo <= {r_quo[ACC_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

// File: src/ramped_gain_limiter.sv
`default_nettype none
// Ramped gain / limiter over four-channel frames. A frame beat is taken every
// cycle unless the output stalls or a ramp division runs; its result passes the
// lane and output registers. Each channel has its own lane (one 24x24 multiplier
// and a clipper), and the result carries a saturating count of samples flagged
// non-finite. An event beat that names this node and parameter sets the target
// level; a jump takes effect at once, while a ramp runs the step division through
// a one-bit-per-cycle divider, holding off the input until the step is ready.
// Only the first LANES channels (up to four) are processed; the rest read zero.
module ramped_gain_limiter #(
    parameter int LANES = 4
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire rgl_pkg::t_in_beat         i_in_data,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output rgl_pkg::t_out_beat             o_out_data,
    input  wire                            i_cfg_we,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [rgl_pkg::LVL_W-1:0] i_cfg_data
);
    import rgl_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_DIV = 2'b10
    } t_state;

    t_state                  r_state;
    logic                    r_mode;
    logic [ID_W-1:0]         r_node;
    logic [ID_W-1:0]         r_param;
    logic signed [ACC_W-1:0] r_cur;
    logic signed [LVL_W-1:0] r_tgt;
    logic signed [ACC_W-1:0] r_step;
    logic [FRM_W-1:0]        r_left;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_sign;
    logic                    r_s1_valid;
    logic [CNT_W-1:0]        r_s1_cnt;
    logic                    r_out_valid;
    t_out_beat               r_out;

    logic                    w_adv;
    logic                    w_acc;
    logic                    w_frame;
    logic                    w_event;
    logic signed [LVL_W-1:0] w_ev_tgt;
    logic [FRM_W-1:0]        w_ev_frames;
    logic signed [ACC_W:0]   w_diff;
    logic signed [ACC_W:0]   w_mag;
    logic signed [ACC_W:0]   w_sum;
    logic signed [ACC_W-1:0] w_sum_sat;
    logic signed [ACC_W-1:0] w_q_step;
    logic signed [LVL_W-1:0] w_ini;
    logic [NUM_CH-1:0]       w_lane_on;
    logic [NUM_CH-1:0]       w_bad;
    logic [2:0]              w_pop;
    logic [CNT_W:0]          w_cnt_sum;
    logic [CNT_W-1:0]        n_cnt;
    t_div_req                w_req;
    t_div_rsp                w_rsp;
    logic signed [SMP_W-1:0] w_smp [NUM_CH];
    logic signed [SMP_W-1:0] w_res [NUM_CH];

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_RUN) || (r_s1_valid && !w_adv);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_frame    = w_acc && (i_in_data.cmd == CMD_FRAME);
    assign w_event    = w_acc && (i_in_data.cmd == CMD_EVENT)
                        && (i_in_data.event_node == r_node)
                        && (i_in_data.event_param == r_param);

    // event target and step dividend
    always_comb begin
        w_ev_tgt    = normalize(r_mode, i_in_data.event_level);
        w_ev_frames = i_in_data.event_linear ? i_in_data.event_ramp_frames : '0;
        w_diff      = {w_ev_tgt[LVL_W-1], w_ev_tgt, {FRAC_X{1'b0}}}
                      - {r_cur[ACC_W-1], r_cur};
        w_mag       = w_diff[ACC_W] ? -w_diff : w_diff;
        w_ini       = normalize(r_mode, i_cfg_data);
    end

    assign w_req.start    = w_event && (w_ev_frames != '0);
    assign w_req.dividend = w_mag[ACC_W-1:0];
    assign w_req.divisor  = w_ev_frames;

    rgl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // signed quotient, saturated to the accumulator
    always_comb begin
        if (r_sign) begin
            if (w_rsp.quotient > {1'b1, {(ACC_W-1){1'b0}}}) begin
                w_q_step = MIN_ACC;
            end else begin
                w_q_step = -w_rsp.quotient;
            end
        end else begin
            if (w_rsp.quotient > {1'b0, {(ACC_W-1){1'b1}}}) begin
                w_q_step = MAX_ACC;
            end else begin
                w_q_step = w_rsp.quotient;
            end
        end
    end

    always_comb begin
        w_sum = {r_cur[ACC_W-1], r_cur} + {r_step[ACC_W-1], r_step};
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_sum_sat = w_sum[ACC_W] ? MIN_ACC : MAX_ACC;
        end else begin
            w_sum_sat = w_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_mode  <= 1'b0;
            r_node  <= 16'd1;
            r_param <= '0;
            r_tgt   <= ONE_Q20;
            r_cur   <= {ONE_Q20, {FRAC_X{1'b0}}};
            r_step  <= '0;
            r_left  <= '0;
            r_sign  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE: begin
                        r_mode <= i_cfg_data[0];
                    end
                    CFG_NODE: begin
                        r_node <= i_cfg_data[ID_W-1:0];
                    end
                    CFG_PARAM: begin
                        r_param <= i_cfg_data[ID_W-1:0];
                    end
                    CFG_INIT: begin
                        r_tgt  <= w_ini;
                        r_cur  <= {w_ini, {FRAC_X{1'b0}}};
                        r_step <= '0;
                        r_left <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (w_event) begin
                r_tgt  <= w_ev_tgt;
                r_left <= w_ev_frames;
                if (w_ev_frames == '0) begin
                    r_cur  <= {w_ev_tgt, {FRAC_X{1'b0}}};
                    r_step <= '0;
                end else begin
                    r_sign  <= w_diff[ACC_W];
                    r_state <= ST_DIV;
                end
            end else if (w_frame) begin
                if (r_left != '0) begin
                    r_left <= r_left - FRM_W'(1);
                    if (r_left == FRM_W'(1)) begin
                        r_cur <= {r_tgt, {FRAC_X{1'b0}}};
                    end else begin
                        r_cur <= w_sum_sat;
                    end
                end
            end else if (r_state == ST_DIV && w_rsp.done) begin
                r_step  <= w_q_step;
                r_state <= ST_RUN;
            end
        end
    end

    // lanes
    assign w_smp[0] = i_in_data.sample_0;
    assign w_smp[1] = i_in_data.sample_1;
    assign w_smp[2] = i_in_data.sample_2;
    assign w_smp[3] = i_in_data.sample_3;

    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        if (g < LANES) begin : g_on
            assign w_lane_on[g] = 1'b1;
            rgl_lane u_lane (
                .i_clk     (i_clk),
                .i_en      (w_frame),
                .i_sample  (w_smp[g]),
                .i_bad     (i_in_data.bad_mask[g]),
                .i_level   (r_cur[ACC_W-1:FRAC_X]),
                .i_limiter (r_mode),
                .o_result  (w_res[g])
            );
        end else begin : g_off
            assign w_lane_on[g] = 1'b0;
            assign w_res[g]     = '0;
        end
    end

    // saturating bad sample count
    always_comb begin
        w_bad = i_in_data.bad_mask & w_lane_on;
        w_pop = 3'(w_bad[0]) + 3'(w_bad[1]) + 3'(w_bad[2]) + 3'(w_bad[3]);
        w_cnt_sum = {1'b0, r_cnt} + {{(CNT_W-2){1'b0}}, w_pop};
        n_cnt = w_cnt_sum[CNT_W] ? {CNT_W{1'b1}} : w_cnt_sum[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_frame) begin
                r_cnt      <= n_cnt;
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_frame) begin
            r_s1_cnt <= n_cnt;
        end
    end

    // merge lane results into the output beat
    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_out.out_0     <= w_res[0];
            r_out.out_1     <= w_res[1];
            r_out.out_2     <= w_res[2];
            r_out.out_3     <= w_res[3];
            r_out.bad_count <= r_s1_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
